>>> src/cph_pkg.sv
// shared types, constants and the crc byte update for the escaped path hash
// no dependencies
`timescale 1ns / 1ps

package cph_pkg;

    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [7:0]  CHAR_HASH   = 8'h23;
    localparam logic [7:0]  CHAR_SLASH  = 8'h2F;
    localparam logic [7:0]  CHAR_BSLASH = 8'h5C;
    localparam logic [7:0]  CHAR_NUL    = 8'h00;
    localparam logic [7:0]  BYTE_MASK   = 8'hFF;

    // number of '#' updates in the restart value
    localparam logic [1:0]  RESTART_STEPS = 2'd3;
    localparam logic [1:0]  HASH_RUN_MAX  = 2'd2;

    // classified byte as it travels from front to back
    typedef struct packed {
        logic        first;
        logic        last;
        logic        is_nul;
        logic        is_bslash;
        logic        is_slash;
        logic        is_hash;
        logic [7:0]  text;
        logic [31:0] start;
    } t_item;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] r;
        r = crc ^ {24'd0, data & BYTE_MASK};
        for (int k = 0; k < 8; k++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

endpackage

>>> src/cph_front.sv
// front end: classifies an incoming byte and forms the string start value
// depends on cph_pkg
`timescale 1ns / 1ps

module cph_front
    import cph_pkg::*;
(
    input  logic [7:0]  i_text_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_seed_value,
    output t_item       o_item
);

    logic is_slash;

    assign is_slash = (i_text_byte == CHAR_SLASH);

    // byte classes and inverted effective seed (leading slash forces zero seed)
    always_comb begin
        o_item.first     = i_first_byte;
        o_item.last      = i_last_byte;
        o_item.is_nul    = (i_text_byte == CHAR_NUL);
        o_item.is_bslash = (i_text_byte == CHAR_BSLASH);
        o_item.is_slash  = is_slash;
        o_item.is_hash   = (i_text_byte == CHAR_HASH);
        o_item.text      = i_text_byte;
        o_item.start     = ~((i_first_byte && is_slash) ? 32'd0 : i_seed_value);
    end

endmodule

>>> src/cph_queue.sv
// two-entry queue of classified bytes between front and back
// depends on cph_pkg
`timescale 1ns / 1ps

module cph_queue
    import cph_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        n_wr_ptr;
    logic        n_rd_ptr;
    logic [1:0]  n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // pointer and fill bookkeeping
    always_comb begin
        n_wr_ptr = i_push ? ~r_wr_ptr : r_wr_ptr;
        n_rd_ptr = i_pop ? ~r_rd_ptr : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

>>> src/cph_back.sv
// back end: crc update, escape and '#' run tracking, result register
// depends on cph_pkg
`timescale 1ns / 1ps

module cph_back
    import cph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_item_valid,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    logic [31:0] r_crc;
    logic        r_esc;
    logic [1:0]  r_run;
    logic        r_term;
    logic [31:0] r_restart;
    logic [1:0]  r_rs_cnt;
    logic        r_out_valid;
    logic [31:0] r_hash;

    logic [31:0] n_crc;
    logic        n_esc;
    logic [1:0]  n_run;
    logic        n_term;
    logic [31:0] n_restart;
    logic [1:0]  n_rs_cnt;
    logic        n_out_valid;
    logic [31:0] n_hash;

    logic [31:0] base_crc;
    logic        base_esc;
    logic [1:0]  base_run;
    logic        base_term;
    logic [31:0] restart_val;
    logic [31:0] byte_crc;

    // take an item unless a finished result is held by the receiver
    assign o_pop        = i_item_valid && !(r_out_valid && i_out_stall);
    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

    // state as seen by this byte: a first byte restarts the string
    always_comb begin
        base_crc  = i_item.first ? i_item.start : r_crc;
        base_esc  = i_item.first ? 1'b0 : r_esc;
        base_run  = i_item.first ? 2'd0 : r_run;
        base_term = i_item.first ? 1'b0 : r_term;
    end

    // restart value: seed updated by three '#', built one update per cycle
    assign restart_val = (r_rs_cnt == RESTART_STEPS) ? r_restart
                                                     : crc_byte(r_restart, CHAR_HASH);
    assign byte_crc    = crc_byte(base_crc, i_item.text);

    always_comb begin
        n_restart = r_restart;
        n_rs_cnt  = r_rs_cnt;
        if (o_pop && i_item.first) begin
            n_restart = crc_byte(i_item.start, CHAR_HASH);
            n_rs_cnt  = 2'd1;
        end else if (r_rs_cnt != RESTART_STEPS) begin
            n_restart = crc_byte(r_restart, CHAR_HASH);
            n_rs_cnt  = r_rs_cnt + 2'd1;
        end
    end

    // per-byte string state update
    always_comb begin
        n_crc  = r_crc;
        n_esc  = r_esc;
        n_run  = r_run;
        n_term = r_term;
        if (o_pop) begin
            n_crc  = base_crc;
            n_esc  = base_esc;
            n_run  = base_run;
            n_term = base_term;
            if (!base_term) begin
                if (i_item.is_nul) begin
                    n_term = 1'b1;
                    n_run  = 2'd0;
                end else if (i_item.is_bslash && !base_esc) begin
                    n_esc = 1'b1;
                    n_run = 2'd0;
                end else if (i_item.is_slash && !base_esc) begin
                    n_run = 2'd0;
                end else begin
                    if (i_item.is_hash && (base_run == HASH_RUN_MAX)) begin
                        n_crc = restart_val;
                    end else begin
                        n_crc = byte_crc;
                    end
                    if (i_item.is_hash) begin
                        n_run = (base_run == HASH_RUN_MAX) ? HASH_RUN_MAX : base_run + 2'd1;
                    end else begin
                        n_run = 2'd0;
                    end
                    n_esc = 1'b0;
                end
            end
        end
    end

    // result register
    always_comb begin
        n_out_valid = r_out_valid;
        n_hash      = r_hash;
        if (o_pop && i_item.last) begin
            n_out_valid = 1'b1;
            n_hash      = ~n_crc;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= 32'd0;
            r_esc       <= 1'b0;
            r_run       <= 2'd0;
            r_term      <= 1'b0;
            r_restart   <= 32'd0;
            r_rs_cnt    <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_crc       <= n_crc;
            r_esc       <= n_esc;
            r_run       <= n_run;
            r_term      <= n_term;
            r_restart   <= n_restart;
            r_rs_cnt    <= n_rs_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
    end

endmodule

>>> src/crc32_escaped_path_hash.sv
// top level of the escaped path hash: front classifier, queue, crc back end
// depends on cph_pkg, cph_front, cph_queue, cph_back
`timescale 1ns / 1ps

// Path string hash, reflected CRC-32 (polynomial EDB88320).
// Input channel: one string byte per transfer (i_in_valid / o_in_stall) with
// first and last markers; the seed is sampled with the first byte.
// Output channel: one hash per string, given on o_hash_value with o_out_valid
// and held while i_out_stall is high.
// Throughput: one byte per cycle while no held result is stalled; the back end
// does a single crc byte update per cycle, with the '#'-run restart value
// prepared alongside it at the start of each string.
// The last byte is written into a queue entry and then taken by the back end,
// whose result register raises o_out_valid.
// A two-entry queue separates the classifier from the crc back end; while the
// receiver stalls a held result, the back end stops, the queue fills and
// o_in_stall rises once both entries are taken.
// Reset (synchronous, active low) empties the queue, drops any pending result
// and clears the crc, escape, run and termination state to zero.

module crc32_escaped_path_hash
    import cph_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_first_byte,
    input  logic        i_last_byte,
    input  logic [31:0] i_seed_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_hash_value
);

    t_item front_item;
    t_item queue_item;
    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  pop;

    // input transfer
    assign push       = i_in_valid && !queue_full;
    assign o_in_stall = queue_full;

    cph_front u_front (
        .i_text_byte  (i_text_byte),
        .i_first_byte (i_first_byte),
        .i_last_byte  (i_last_byte),
        .i_seed_value (i_seed_value),
        .o_item       (front_item)
    );

    cph_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (queue_item),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    cph_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (queue_item),
        .i_item_valid (!queue_empty),
        .o_pop        (pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_hash_value (o_hash_value)
    );

endmodule
